// ===== hdl/key_scan_midi_voice_allocator_defines.svh =====
// Assertion macros for the key-scan MIDI voice allocator checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef KEY_SCAN_MIDI_VOICE_ALLOCATOR_DEFINES_SVH
`define KEY_SCAN_MIDI_VOICE_ALLOCATOR_DEFINES_SVH

// Property checked outside reset only.
`define KSMVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define KSMVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ksmva_pkg.sv =====
// Shared types and constants for the key-scan MIDI voice allocator.
// No dependencies; imported by the voice table and the top level.
`default_nettype none

package ksmva_pkg;

  // Register and field widths fixed by the message format
  localparam int OCTAVE_W   = 4;
  localparam int VEL_W      = 7;
  localparam int NOTE_W     = 7;
  localparam int OFFSET_W   = 4;
  localparam int OFFSETS_W  = 52;
  localparam int OWNER_W    = 4;
  localparam int STATUS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;

  // Message and table codes
  localparam logic [OWNER_W-1:0] FREE_CODE  = 4'hF;
  localparam logic [3:0]         STATUS_ON  = 4'h9;
  localparam logic [3:0]         STATUS_OFF = 4'h8;

  // Register reset values
  localparam logic [OCTAVE_W-1:0]  OCTAVE_RST  = 4'd4;
  localparam logic [VEL_W-1:0]     VEL_RST     = 7'd64;
  localparam logic [OFFSETS_W-1:0] OFFSETS_RST = 52'hCBA9876012345;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE       = 2'd0,
    CFG_VELOCITY     = 2'd1,
    CFG_KEY_ENABLE   = 2'd2,
    CFG_NOTE_OFFSETS = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_VOICE,
    ST_DONE
  } state_t;

  // Request from the sequencer to the voice table
  typedef struct packed {
    logic               commit;
    logic               claim;
    logic [OWNER_W-1:0] key;
  } vt_req_t;

endpackage

`default_nettype wire

// ===== hdl/ksmva_voice_table.sv =====
// Voice owner table with its single match unit for the voice allocator.
// Depends on ksmva_pkg for the request struct and the free code.
`default_nettype none

module ksmva_voice_table #(
  parameter int VOICE_COUNT = 4,
  parameter int VW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VW-1:0]      voice_idx,
  input  ksmva_pkg::vt_req_t req,
  output logic               hit
);
  import ksmva_pkg::*;

  logic [OWNER_W-1:0] owner_r [VOICE_COUNT];
  logic [OWNER_W-1:0] owner;
  logic               owned;

  // Match the selected voice against the key
  assign owner = owner_r[voice_idx];
  assign owned = (owner == req.key);
  assign hit   = req.claim ? (owned || (owner == FREE_CODE)) : owned;

  // Claim or free the selected voice on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        owner_r[v] <= FREE_CODE;
      end
    end else if (req.commit && hit) begin
      owner_r[voice_idx] <= req.claim ? req.key : FREE_CODE;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/key_scan_midi_voice_allocator.sv =====
// Key-scan MIDI voice allocator: takes one scan of active-low key levels per item and
// emits one note on / note off item for each changed, enabled key that claims or frees
// a voice. A scan in which no enabled key changed is taken in ST_IDLE and
// the block stays ready. Otherwise the sequencer walks the keys one per cycle and, for
// each changed key, probes the voice table one voice per cycle through its single
// match unit, holding on a hit while the held-back result cannot move out, then
// finishes in ST_DONE. One result is held back until the next is found so that the
// final item of a scan carries last_message. Depends on ksmva_pkg and ksmva_voice_table.
`default_nettype none

module key_scan_midi_voice_allocator #(
  parameter int KEY_COUNT   = 13,
  parameter int VOICE_COUNT = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // scan items
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [KEY_COUNT-1:0]                   in_key_levels,
  // message items
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ksmva_pkg::STATUS_W-1:0]         out_status_byte,
  output logic [ksmva_pkg::NOTE_W-1:0]           out_note_number,
  output logic [ksmva_pkg::VEL_W-1:0]            out_note_velocity,
  output logic                                   out_last_message,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ksmva_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ksmva_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ksmva_pkg::*;

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [KW-1:0] KEY_LAST   = KW'(KEY_COUNT - 1);
  localparam logic [VW-1:0] VOICE_LAST = VW'(VOICE_COUNT - 1);

  // configuration registers
  logic [OCTAVE_W-1:0]  octave_r;
  logic [VEL_W-1:0]     velocity_r;
  logic [KEY_COUNT-1:0] enable_r;
  logic [OFFSETS_W-1:0] offsets_r;

  // sequencer state
  state_t               state_r, state_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic [VW-1:0]        voice_r, voice_nxt;
  logic [KEY_COUNT-1:0] levels_r, levels_nxt;
  logic [KEY_COUNT-1:0] changed_r, changed_nxt;
  logic [KEY_COUNT-1:0] prev_r, prev_nxt;

  // held-back message
  logic                 pend_valid_r, pend_valid_nxt;
  logic [STATUS_W-1:0]  pend_status_r, pend_status_nxt;
  logic [NOTE_W-1:0]    pend_note_r, pend_note_nxt;

  // output register
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [NOTE_W-1:0]    out_note_r;
  logic [VEL_W-1:0]     out_vel_r;
  logic                 out_last_r;
  logic                 out_load;
  logic                 out_load_last;
  logic                 out_free;

  // datapath
  logic                 released;
  logic [OFFSET_W-1:0]  offset;
  logic [NOTE_W-1:0]    octave_x12;
  logic [NOTE_W-1:0]    note;
  logic [STATUS_W-1:0]  status;
  logic [KEY_COUNT-1:0] scan_changed;
  vt_req_t              vt_req;
  logic                 vt_hit;

  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r   <= OCTAVE_RST;
      velocity_r <= VEL_RST;
      enable_r   <= '1;
      offsets_r  <= OFFSETS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OCTAVE:       octave_r   <= cfg_data[OCTAVE_W-1:0];
        CFG_VELOCITY:     velocity_r <= cfg_data[VEL_W-1:0];
        CFG_KEY_ENABLE:   enable_r   <= cfg_data[KEY_COUNT-1:0];
        CFG_NOTE_OFFSETS: offsets_r  <= cfg_data[OFFSETS_W-1:0];
        default: ;
      endcase
    end
  end

  // Build the message for the current key and voice
  assign released   = levels_r[key_r];
  assign offset     = OFFSET_W'(offsets_r >> {key_r, 2'b00});
  assign octave_x12 = NOTE_W'({octave_r, 3'b000}) + NOTE_W'({octave_r, 2'b00});
  assign note       = NOTE_W'(offset) + octave_x12;
  assign status     = {(released ? STATUS_OFF : STATUS_ON), 4'(voice_r)};
  assign scan_changed = enable_r & (prev_r ^ in_key_levels);
  assign out_free   = !out_valid_r || out_ready;

  ksmva_voice_table #(
    .VOICE_COUNT (VOICE_COUNT),
    .VW          (VW)
  ) u_voice_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .voice_idx (voice_r),
    .req       (vt_req),
    .hit       (vt_hit)
  );

  // Sequence keys and voices
  always_comb begin
    state_nxt       = state_r;
    key_nxt         = key_r;
    voice_nxt       = voice_r;
    levels_nxt      = levels_r;
    changed_nxt     = changed_r;
    prev_nxt        = prev_r;
    pend_valid_nxt  = pend_valid_r;
    pend_status_nxt = pend_status_r;
    pend_note_nxt   = pend_note_r;
    out_load        = 1'b0;
    out_load_last   = 1'b0;
    in_ready        = 1'b0;
    vt_req.commit   = 1'b0;
    vt_req.claim    = !released;
    vt_req.key      = OWNER_W'(key_r);

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          levels_nxt  = in_key_levels;
          changed_nxt = scan_changed;
          key_nxt     = '0;
          if (|scan_changed) begin
            state_nxt = ST_KEY;
          end
        end
      end

      ST_KEY: begin
        if (changed_r[key_r]) begin
          voice_nxt = '0;
          state_nxt = ST_VOICE;
        end else if (key_r == KEY_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          key_nxt = key_r + 1'b1;
        end
      end

      ST_VOICE: begin
        if (vt_hit) begin
          // hold until the previous message can move out
          if (!pend_valid_r || out_free) begin
            vt_req.commit   = 1'b1;
            out_load        = pend_valid_r;
            pend_valid_nxt  = 1'b1;
            pend_status_nxt = status;
            pend_note_nxt   = note;
            if (key_r == KEY_LAST) begin
              state_nxt = ST_DONE;
            end else begin
              key_nxt   = key_r + 1'b1;
              state_nxt = ST_KEY;
            end
          end
        end else if (voice_r == VOICE_LAST) begin
          if (key_r == KEY_LAST) begin
            state_nxt = ST_DONE;
          end else begin
            key_nxt   = key_r + 1'b1;
            state_nxt = ST_KEY;
          end
        end else begin
          voice_nxt = voice_r + 1'b1;
        end
      end

      ST_DONE: begin
        if (!pend_valid_r) begin
          prev_nxt  = levels_r;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_load_last  = 1'b1;
          pend_valid_nxt = 1'b0;
          prev_nxt       = levels_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prev_r       <= '0;
      pend_valid_r <= 1'b0;
      key_r        <= '0;
      voice_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      prev_r       <= prev_nxt;
      pend_valid_r <= pend_valid_nxt;
      key_r        <= key_nxt;
      voice_r      <= voice_nxt;
    end
  end

  // Hold scan and pending payload
  always_ff @(posedge clk) begin
    levels_r      <= levels_nxt;
    changed_r     <= changed_nxt;
    pend_status_r <= pend_status_nxt;
    pend_note_r   <= pend_note_nxt;
  end

  // Output register: load from the pending message, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_note_r   <= pend_note_r;
      out_vel_r    <= velocity_r;
      out_last_r   <= out_load_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status_byte   = out_status_r;
  assign out_note_number   = out_note_r;
  assign out_note_velocity = out_vel_r;
  assign out_last_message  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/ksmva_checker.sv =====
// Port-level checks for the key-scan MIDI voice allocator, bound to the top level.
// Depends on key_scan_midi_voice_allocator_defines.svh for the assertion macros.
`default_nettype none

`include "key_scan_midi_voice_allocator_defines.svh"

module ksmva_checker #(
  parameter int VOICE_COUNT = 4
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_status_byte,
  input wire logic [6:0] out_note_number,
  input wire logic [6:0] out_note_velocity,
  input wire logic       out_last_message
);

  // a stalled message item holds still
  `KSMVA_ASSERT(a_out_hold, (out_valid && !out_ready |=> out_valid && $stable(out_status_byte) && $stable(out_note_number) && $stable(out_note_velocity) && $stable(out_last_message)), "stalled message item changed")

  // status is note on or note off for an existing voice
  `KSMVA_ASSERT(a_status_code, (out_valid |-> (out_status_byte[7:5] == 3'b100) && (out_status_byte[3:0] <= 4'(VOICE_COUNT - 1))), "bad status byte")

  // reset leaves the block ready with nothing to deliver
  `KSMVA_ASSERT_ALWAYS(a_reset_state, (!rst_n |=> in_ready && !out_valid), "not idle after reset")

endmodule

bind key_scan_midi_voice_allocator ksmva_checker #(
  .VOICE_COUNT (VOICE_COUNT)
) u_ksmva_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status_byte   (out_status_byte),
  .out_note_number   (out_note_number),
  .out_note_velocity (out_note_velocity),
  .out_last_message  (out_last_message)
);

`default_nettype wire

// ===== tb/sv/key_scan_midi_voice_allocator_tb.sv =====
// Self-checking testbench for key_scan_midi_voice_allocator: key scans go in and
// note on / note off messages are checked against an in-bench voice allocation model.
// Depends on ksmva_pkg and the allocator RTL only.
module key_scan_midi_voice_allocator_tb;
  import ksmva_pkg::*;

  localparam int KEYS = 13;
  localparam int VOICES = 4;
  localparam logic [7:0] SEMITONES = 8'h0C;
  localparam int SETTLE_CYCLES = 90;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    vel;
    logic                last_msg;
  } note_msg_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [KEYS-1:0] in_key_levels;
  logic out_valid;
  logic out_ready;
  logic [STATUS_W-1:0] out_status_byte;
  logic [NOTE_W-1:0] out_note_number;
  logic [VEL_W-1:0] out_note_velocity;
  logic out_last_message;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Allocation model state and register copies
  logic [KEYS-1:0]      shadow_prev_levels;
  logic [OWNER_W-1:0]   shadow_owner [VOICES];
  logic [OCTAVE_W-1:0]  reg_octave;
  logic [VEL_W-1:0]     reg_velocity;
  logic [KEYS-1:0]      reg_key_enable;
  logic [OFFSETS_W-1:0] reg_note_offsets;

  note_msg_t pending_msgs [$];
  note_msg_t got_msg;
  note_msg_t want_msg;
  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  logic [KEYS-1:0] finger_levels;

  key_scan_midi_voice_allocator #(
    .KEY_COUNT(KEYS),
    .VOICE_COUNT(VOICES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_key_levels(in_key_levels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status_byte(out_status_byte),
    .out_note_number(out_note_number),
    .out_note_velocity(out_note_velocity),
    .out_last_message(out_last_message),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the messages one accepted scan causes and queue them
  function automatic void allocate_notes(input logic [KEYS-1:0] levels);
    logic [KEYS-1:0] changed;
    note_msg_t msgs [KEYS];
    int n_msgs;
    int voice;
    logic [7:0] note_sum;
    changed = reg_key_enable & (shadow_prev_levels ^ levels);
    if (changed == '0) return;
    n_msgs = 0;
    for (int k = 0; k < KEYS; k++) begin
      if (changed[k]) begin
        voice = -1;
        // first matching voice: own or free for a press, own for a release
        for (int v = 0; v < VOICES; v++) begin
          if (voice < 0) begin
            if (!levels[k] && (shadow_owner[v] == 4'(k) || shadow_owner[v] == FREE_CODE)) begin
              shadow_owner[v] = 4'(k);
              voice = v;
            end else if (levels[k] && shadow_owner[v] == 4'(k)) begin
              shadow_owner[v] = FREE_CODE;
              voice = v;
            end
          end
        end
        if (voice >= 0) begin
          note_sum = 8'(reg_note_offsets[4*k +: 4]) + 8'(reg_octave) * SEMITONES;
          msgs[n_msgs].status = {(levels[k] ? STATUS_OFF : STATUS_ON), 4'(voice)};
          msgs[n_msgs].note = note_sum[NOTE_W-1:0];
          msgs[n_msgs].vel = reg_velocity;
          msgs[n_msgs].last_msg = 1'b0;
          n_msgs++;
        end
      end
    end
    for (int i = 0; i < n_msgs; i++) begin
      msgs[i].last_msg = (i == n_msgs - 1);
      pending_msgs.push_back(msgs[i]);
    end
    shadow_prev_levels = levels;
  endfunction

  // Predict on every accepted scan item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) allocate_notes(in_key_levels);
  end

  // Compare every accepted message item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_msg = '{out_status_byte, out_note_number, out_note_velocity, out_last_message};
      if (pending_msgs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected message: status %h note %0d vel %0d last %0b",
                   got_msg.status, got_msg.note, got_msg.vel, got_msg.last_msg);
      end else begin
        want_msg = pending_msgs.pop_front();
        if (got_msg != want_msg) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"message mismatch: expected status %h note %0d vel %0d last %0b,",
                      " got status %h note %0d vel %0d last %0b"},
                     want_msg.status, want_msg.note, want_msg.vel, want_msg.last_msg,
                     got_msg.status, got_msg.note, got_msg.vel, got_msg.last_msg);
        end
      end
    end
  end

  // Stall the message side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one scan item; valid stays high afterwards unless a gap or settle drops it
  task automatic send_scan(input logic [KEYS-1:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every predicted message has come and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OCTAVE:       reg_octave = data[OCTAVE_W-1:0];
      CFG_VELOCITY:     reg_velocity = data[VEL_W-1:0];
      CFG_KEY_ENABLE:   reg_key_enable = data[KEYS-1:0];
      CFG_NOTE_OFFSETS: reg_note_offsets = data[OFFSETS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // From power-up: unchanged scan, releases with no voice, all keys pressed
  task automatic test_power_up_scans();
    send_scan(13'h0000);
    send_scan(13'h1FFF);
    send_scan(13'h0000);
    send_scan(13'h1FFF);
    send_scan(13'h0FFE);
    send_scan(13'h1FFF);
  endtask

  // Register extremes: note overflow, top octave, zero velocity, all keys disabled
  task automatic test_register_extremes();
    write_reg(CFG_OCTAVE, '1);
    write_reg(CFG_VELOCITY, '1);
    write_reg(CFG_KEY_ENABLE, '1);
    write_reg(CFG_NOTE_OFFSETS, '1);
    send_scan(13'h1FFE);
    send_scan(13'h1FFF);
    write_reg(CFG_OCTAVE, 52'd9);
    write_reg(CFG_VELOCITY, '0);
    send_scan(13'h0FFF);
    send_scan(13'h1FFF);
    write_reg(CFG_OCTAVE, '0);
    write_reg(CFG_KEY_ENABLE, '0);
    write_reg(CFG_NOTE_OFFSETS, '0);
    send_scan(13'h0000);
    send_scan(13'h1FFF);
    write_reg(CFG_KEY_ENABLE, 52'h1FFF);
    send_scan(13'h1FFE);
    send_scan(13'h1FFF);
    write_reg(CFG_OCTAVE, 52'(OCTAVE_RST));
    write_reg(CFG_VELOCITY, 52'(VEL_RST));
    write_reg(CFG_NOTE_OFFSETS, OFFSETS_RST);
  endtask

  // One key in two voices: a press claims the first, a release frees the first
  task automatic test_duplicate_claim();
    send_scan(13'h1FFD);
    send_scan(13'h1FFC);
    send_scan(13'h1FFE);
    // release key 0 unseen, then press it into the free voice ahead of its own
    write_reg(CFG_KEY_ENABLE, 52'h1FFE);
    send_scan(13'h1FFB);
    send_scan(13'h1FFF);
    write_reg(CFG_KEY_ENABLE, 52'h1FFF);
    send_scan(13'h1FFE);
    // release unseen again, press again: must reuse the lower voice
    write_reg(CFG_KEY_ENABLE, 52'h1FFE);
    send_scan(13'h1FFB);
    send_scan(13'h1FFF);
    write_reg(CFG_KEY_ENABLE, 52'h1FFF);
    send_scan(13'h1FFE);
    send_scan(13'h1FFF);
    // press unseen, then release to free the remaining voice
    write_reg(CFG_KEY_ENABLE, 52'h1FFE);
    send_scan(13'h1FFA);
    send_scan(13'h1FFE);
    write_reg(CFG_KEY_ENABLE, 52'h1FFF);
    send_scan(13'h1FFF);
  endtask

  // Mostly a few keys moving like fingers, some noise scans and repeats
  function automatic logic [KEYS-1:0] next_finger_scan();
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 5) return finger_levels;
    if (pick < 15) begin
      finger_levels = KEYS'($urandom);
      return finger_levels;
    end
    for (int i = 0; i < $urandom_range(1, 3); i++) begin
      k = $urandom_range(KEYS - 1);
      if (!finger_levels[k] || $countones(~finger_levels) < $urandom_range(2, 7))
        finger_levels[k] = ~finger_levels[k];
    end
    return finger_levels;
  endfunction

  // Random register settings, each followed by a run of random scans
  task automatic random_setting(input int n_scans);
    logic [CFG_DATA_W-1:0] junk;
    logic [OCTAVE_W-1:0] oct;
    logic [VEL_W-1:0] vel;
    junk = CFG_DATA_W'({$urandom, $urandom});
    case ($urandom_range(3))
      0: oct = '0;
      1: oct = 4'd9;
      2: oct = '1;
      default: oct = OCTAVE_W'($urandom);
    endcase
    write_reg(CFG_OCTAVE, {junk[CFG_DATA_W-1:OCTAVE_W], oct});
    case ($urandom_range(2))
      0: vel = '0;
      1: vel = '1;
      default: vel = VEL_W'($urandom);
    endcase
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_VELOCITY, {junk[CFG_DATA_W-1:VEL_W], vel});
    junk = CFG_DATA_W'({$urandom, $urandom});
    if ($urandom_range(1)) junk[KEYS-1:0] = '1;
    else junk[KEYS-1:0] = KEYS'($urandom | $urandom);
    write_reg(CFG_KEY_ENABLE, junk);
    junk = CFG_DATA_W'({$urandom, $urandom});
    if ($urandom_range(7) == 0) junk = '1;
    write_reg(CFG_NOTE_OFFSETS, junk);
    for (int i = 0; i < n_scans; i++) send_scan(next_finger_scan());
  endtask

  // Three idling patterns, four register settings each
  task automatic test_random_traffic();
    finger_levels = '1;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 20; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) random_setting(25);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_levels = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 20;
    recv_idle_pct = 86;
    reg_octave = OCTAVE_RST;
    reg_velocity = VEL_RST;
    reg_key_enable = '1;
    reg_note_offsets = OFFSETS_RST;
    shadow_prev_levels = '0;
    for (int v = 0; v < VOICES; v++) shadow_owner[v] = FREE_CODE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_up_scans();
    test_register_extremes();
    test_duplicate_claim();
    test_random_traffic();
    settle();
    if (mismatch_count == 0 && pending_msgs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ksmva_pkg.sv
hdl/ksmva_voice_table.sv
hdl/key_scan_midi_voice_allocator.sv
hdl/ksmva_checker.sv
tb/sv/key_scan_midi_voice_allocator_tb.sv
